// File: src/pwmm_pkg.sv
// Shared types, constants and the reciprocal table for the PCM window min/max block.
package pwmm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int SAMPLE_W   = 16;  // sample and result field width
    localparam int WIN_W      = 16;  // window_frames width
    localparam int REG_W      = 16;  // widest configuration register
    localparam int CFG_ADDR_W = 2;
    localparam int CNT_W      = 5;   // effective channel count, up to 16
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_SELECT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_FRAMES  = 2'd2;

    localparam logic [3:0]       CHANNEL_COUNT_RST  = 4'd2;
    localparam logic [3:0]       CHANNEL_SELECT_RST = 4'd0;
    localparam logic [WIN_W-1:0] WINDOW_FRAMES_RST  = 16'd256;

    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic div_mul;  // reciprocal multiply
        logic div_fix;  // quotient correction and sign
        logic div_ins;  // mean enters the range
        logic emit;     // load result register, clear range
    } pwmm_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic mean_mode;
        logic win_end;
        logic out_free;
    } pwmm_status_t;

    // floor(2^RECIP_SHIFT / c) for c = 1..16
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
        logic [RECIP_W-1:0] r;
        unique case (c)
            5'd1:    r = 21'd1048576;
            5'd2:    r = 21'd524288;
            5'd3:    r = 21'd349525;
            5'd4:    r = 21'd262144;
            5'd5:    r = 21'd209715;
            5'd6:    r = 21'd174762;
            5'd7:    r = 21'd149796;
            5'd8:    r = 21'd131072;
            5'd9:    r = 21'd116508;
            5'd10:   r = 21'd104857;
            5'd11:   r = 21'd95325;
            5'd12:   r = 21'd87381;
            5'd13:   r = 21'd80659;
            5'd14:   r = 21'd74898;
            5'd15:   r = 21'd69905;
            5'd16:   r = 21'd65536;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

// File: src/pwmm_ctrl.sv
// Sequencer: input acceptance, mean division steps and result emission.
module pwmm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  ready,
    input  pwmm_pkg::pwmm_status_t status,
    output pwmm_pkg::pwmm_cmd_t    cmd
);
    import pwmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_INS,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   win_pend_reg, win_pend_next;

    always_comb
    begin
        state_next    = state_reg;
        win_pend_next = win_pend_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    win_pend_next = status.win_end;
                    if (status.frame_end && status.mean_mode)
                        state_next = ST_MUL;
                    else if (status.win_end)
                        state_next = ST_EMIT;
                end
            end
            ST_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_INS;
            end
            ST_INS:
            begin
                cmd.div_ins = 1'b1;
                state_next  = win_pend_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // wait for the result register to drain
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            win_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            win_pend_reg <= win_pend_next;
        end
    end

    assign ready = (state_reg == ST_IDLE);

endmodule

// File: src/pwmm_datapath.sv
// Datapath: config registers, frame accumulation, divide by channel count, range and result.
module pwmm_datapath #(
    parameter int MAX_CHANNELS = pwmm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = pwmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pwmm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pwmm_pkg::REG_W-1:0]        cfg_data,
    input  logic [pwmm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [pwmm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  pwmm_pkg::pwmm_cmd_t               cmd,
    output pwmm_pkg::pwmm_status_t            status
);
    import pwmm_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS) + 1;
    localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QC_W   = SUM_W + CNT_W;
    localparam int PAD_W  = M_TDATA_W - 2 * SAMPLE_W - 1;

    // configuration
    logic [3:0]       channel_count_reg;
    logic [3:0]       channel_select_reg;
    logic [WIN_W-1:0] window_frames_reg;

    // frame and window state
    // range is kept at sum width: a frame left open across a count change can
    // give a mean beyond the sample range; only the result is cut to 16 bits
    logic [POS_W-1:0]              pos_reg;
    logic signed [SUM_W-1:0]       frame_sum_reg;
    logic [WIN_W-1:0]              frame_counter_reg;
    logic signed [SUM_W-1:0]       min_reg, max_reg;
    logic                          nonempty_reg;

    // divider
    logic [SUM_W-1:0]              mag_reg;
    logic                          neg_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic signed [SUM_W-1:0]       mean_reg;

    // result register
    logic                    m_tvalid_reg;
    logic [SAMPLE_W-1:0]     out_min_reg, out_max_reg;
    logic                    out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [SUM_W-1:0]       smp_ext, sum_total;
    logic [SUM_W-1:0]              mag;
    logic [CNT_W-1:0]              cnt_ext, cnt_eff, sel_ext, pos_ext;
    logic [WIN_W-1:0]              win_eff;
    logic [WIN_W:0]                cnt_inc;
    logic                          sel_hit, frame_end, win_end;
    logic [SUM_W-1:0]              q0, q_fix;
    logic [QC_W-1:0]               qc, rem;
    logic                          ins_en;
    logic signed [SUM_W-1:0]       ins_val;

    assign smp       = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign smp_ext   = SUM_W'(smp);
    assign sum_total = frame_sum_reg + smp_ext;
    assign mag       = sum_total[SUM_W-1] ? SUM_W'(-sum_total) : SUM_W'(sum_total);

    assign cnt_ext = {1'b0, channel_count_reg};
    assign sel_ext = {1'b0, channel_select_reg};
    assign pos_ext = CNT_W'(pos_reg);

    always_comb
    begin
        priority if (channel_count_reg == '0)
            cnt_eff = CNT_W'(1);
        else if (cnt_ext > CNT_W'(MAX_CHANNELS))
            cnt_eff = CNT_W'(MAX_CHANNELS);
        else
            cnt_eff = cnt_ext;
    end

    assign win_eff   = (window_frames_reg == '0) ? WIN_W'(1) : window_frames_reg;
    assign sel_hit   = (channel_select_reg != '0) && (sel_ext <= cnt_eff)
                       && (pos_ext == sel_ext - CNT_W'(1));
    assign frame_end = (pos_ext + CNT_W'(1)) >= cnt_eff;
    assign cnt_inc   = {1'b0, frame_counter_reg} + (WIN_W + 1)'(1);
    assign win_end   = frame_end && (cnt_inc >= {1'b0, win_eff});

    // quotient estimate is exact or one short; one compare fixes it
    assign q0    = prod_reg[RECIP_SHIFT +: SUM_W];
    assign qc    = QC_W'(q0) * QC_W'(cnt_eff);
    assign rem   = QC_W'(mag_reg) - qc;
    assign q_fix = (rem >= QC_W'(cnt_eff)) ? q0 + SUM_W'(1) : q0;

    assign ins_en  = (cmd.accept && sel_hit) || cmd.div_ins;
    assign ins_val = cmd.div_ins ? mean_reg : smp_ext;

    assign status.frame_end = frame_end;
    assign status.mean_mode = (channel_select_reg == '0);
    assign status.win_end   = win_end;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg  <= CHANNEL_COUNT_RST;
            channel_select_reg <= CHANNEL_SELECT_RST;
            window_frames_reg  <= WINDOW_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[3:0];
                CFG_CHANNEL_SELECT: channel_select_reg <= cfg_data[3:0];
                CFG_WINDOW_FRAMES:  window_frames_reg  <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            frame_sum_reg     <= '0;
            frame_counter_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (frame_end)
            begin
                pos_reg           <= '0;
                frame_sum_reg     <= '0;
                frame_counter_reg <= win_end ? '0 : cnt_inc[WIN_W-1:0];
            end
            else
            begin
                pos_reg       <= pos_reg + POS_W'(1);
                frame_sum_reg <= sum_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= '0;
            max_reg      <= '0;
            nonempty_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            min_reg      <= '0;
            max_reg      <= '0;
            nonempty_reg <= 1'b0;
        end
        else if (ins_en)
        begin
            nonempty_reg <= 1'b1;
            if (!nonempty_reg || ins_val < min_reg)
                min_reg <= ins_val;
            if (!nonempty_reg || ins_val > max_reg)
                max_reg <= ins_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_reg <= mag;
            neg_reg <= sum_total[SUM_W-1];
        end
        if (cmd.div_mul)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(recip(cnt_eff));
        if (cmd.div_fix)
            mean_reg <= neg_reg ? $signed(-q_fix) : $signed(q_fix);
        if (cmd.emit)
        begin
            out_min_reg   <= nonempty_reg ? SAMPLE_W'(min_reg) : '0;
            out_max_reg   <= nonempty_reg ? SAMPLE_W'(max_reg) : '0;
            out_valid_reg <= nonempty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_valid_reg, out_max_reg, out_min_reg};

endmodule

// File: src/pcm_window_min_max.sv
// Top level: minimum and maximum of per-frame PCM values over a window of frames.
//
// Input stream s_*: one interleaved signed sample per transfer, channels in order.
// Output stream m_*: one transfer per window with range_min, range_max and
// range_valid (0 when no value entered the range; min and max are then 0).
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 channel_count,
// 1 channel_select, 2 window_frames); write only while the block is idle.
//
// Throughput: one sample per cycle while s_tready is high. A sample that closes a frame in mean mode
// (channel_select 0) holds s_tready low while the frame sum goes through a reciprocal
// multiply, a correction step and the range update. A sample that closes a
// window also holds s_tready low until the result register is loaded.
//
// Reset clears the channel position, frame sum, frame count and range, and
// loads channel_count 2, channel_select 0, window_frames 256. The result
// register holds one window result; a stalled receiver only blocks input when
// a second result is ready to be loaded.
module pcm_window_min_max #(
    parameter int MAX_CHANNELS = pwmm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = pwmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pwmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pwmm_pkg::REG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pwmm_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pwmm_pkg::M_TDATA_W-1:0]  m_tdata    // [15:0] range_min, [31:16] range_max,
                                                       // [32] range_valid
);
    import pwmm_pkg::*;

    pwmm_cmd_t    cmd;
    pwmm_status_t status;

    pwmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .ready    (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pwmm_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2*SAMPLE_W] |-> m_tdata[2*SAMPLE_W-1:0] == '0)
        else $error("empty range result carries non-zero min or max");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("result raised without an emit");

    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_mul |=> cmd.div_fix && !s_tready)
        else $error("divider steps out of order");

endmodule
